FILE: src/pads_pkg.sv
// Package for the PWM angle decoder: widths and constants.
package pads_pkg;

  localparam int unsigned MinPeriod = 900;
  localparam int unsigned TwoPiQ16 = 411775;
  localparam logic [63:0] MicroQ16 = 64'd65536000000;
  localparam int unsigned DivW = 64;

  // configuration register indexes
  localparam logic CfgAngleCutoff = 1'b0;
  localparam logic CfgSpeedCutoff = 1'b1;

endpackage

FILE: src/pads_if.sv
// Valid/ready channel interfaces for input and result transactions.
interface pads_in_if;
  logic valid;
  logic ready;
  logic [19:0] high_time_us;
  logic [19:0] period_us;
  modport source(output valid, high_time_us, period_us, input ready);
  modport sink(input valid, high_time_us, period_us, output ready);
endinterface

interface pads_out_if;
  logic valid;
  logic ready;
  logic [15:0] angle;
  logic [31:0] speed;
  logic speed_valid;
  modport source(output valid, angle, speed, speed_valid, input ready);
  modport sink(input valid, angle, speed, speed_valid, output ready);
endinterface

FILE: src/pads_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module pads_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [pads_pkg::DivW-1:0] num,
  input  logic [pads_pkg::DivW-1:0] den,
  output logic done,
  output logic [pads_pkg::DivW-1:0] quo
);
  logic [pads_pkg::DivW-1:0] q;
  logic [pads_pkg::DivW-1:0] d;
  logic [pads_pkg::DivW:0] r;
  logic [6:0] cnt;
  logic busy;
  logic [pads_pkg::DivW:0] trial;

  assign trial = {r[pads_pkg::DivW-1:0], q[pads_pkg::DivW-1]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 7'(pads_pkg::DivW);
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      d <= den;
      r <= '0;
    end else if (busy) begin
      // shift in next numerator bit, subtract when it fits
      if (!trial[pads_pkg::DivW]) begin
        r <= trial;
        q <= {q[pads_pkg::DivW-2:0], 1'b1};
      end else begin
        r <= {r[pads_pkg::DivW-1:0], q[pads_pkg::DivW-1]};
        q <= {q[pads_pkg::DivW-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: src/pwm_angle_decoder_speed_filter.sv
// Top level: PWM duty angle decode, unwrap, angle and speed IIR filters.
// Each transaction runs up to four passes of the bit-serial divider and two
// 17-step shift-add multiplies; fewer while settling.
// Throughput: one transaction at a time; next input is taken the cycle after the result leaves.
// Reset (rst, synchronous) clears filter state, restores cutoffs 50/10 Hz,
// reloads the settle count and marks the next sample as the first.
module pwm_angle_decoder_speed_filter #(
  parameter int TOTAL_TICKS = 4351,
  parameter int PAD_TICKS = 128,
  parameter int SPAN_TICKS = 4095,
  parameter int SETTLE_ITEMS = 50
) (
  input  logic clk,
  input  logic rst,
  pads_in_if.sink in_ch,
  pads_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RAW = 4'd1, S_AL1 = 4'd2, S_AL2 = 4'd3,
    S_AF = 4'd4, S_SP = 4'd5, S_SA1 = 4'd6, S_SA2 = 4'd7, S_SF = 4'd8,
    S_OUT = 4'd9, S_MUL = 4'd10;

  logic [3:0] state, ret;
  logic [15:0] cut_a, cut_s;
  logic [15:0] last_raw, prev_out, raw;
  logic [31:0] unwr, acc_a;
  logic signed [31:0] acc_s;
  logic [5:0] settle;
  logic first;
  logic [19:0] p;
  logic [19:0] hi;
  logic [16:0] alpha;
  logic [63:0] mulb, prod;
  logic [16:0] mula;
  logic [4:0] mcnt;
  logic neg;
  logic signed [32:0] e33;
  logic signed [33:0] spd;

  logic dstart, ddone;
  logic [63:0] dnum, dden, dq;
  pads_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dq));

  logic [39:0] pos, negv, span, dd;
  assign pos = 40'(hi) * 40'(TOTAL_TICKS);
  assign negv = 40'(PAD_TICKS) * 40'(p);
  assign span = 40'(SPAN_TICKS) * 40'(p);
  assign dd = pos - negv;

  function automatic logic signed [17:0] wdiff(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] t;
    t = a - b;
    if (t == 16'h8000) wdiff = 18'sd32768;
    else wdiff = 18'(signed'(t));
  endfunction

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  logic [63:0] kfc;
  logic [35:0] pfc;
  logic pend;

  // shift-add multiply: alpha (17 bits) times magnitude, one bit per cycle
  logic signed [33:0] qv;
  assign qv = neg ? -34'(prod >> 16) : 34'(prod >> 16);
  logic signed [33:0] nv;
  assign nv = 34'(acc_s) + qv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      cut_a <= 16'd50;
      cut_s <= 16'd10;
      last_raw <= '0; prev_out <= '0; unwr <= '0; acc_a <= '0; acc_s <= '0;
      settle <= 6'(SETTLE_ITEMS);
      first <= 1'b1;
      out_ch.valid <= 1'b0;
      dstart <= 1'b0;
      pend <= 1'b0;
    end else begin
      // drop the start pulse; no state raises it while it is high
      if (dstart) dstart <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          pads_pkg::CfgAngleCutoff: cut_a <= cfg_data;
          pads_pkg::CfgSpeedCutoff: cut_s <= cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          hi <= in_ch.high_time_us;
          p <= (in_ch.period_us < 20'(pads_pkg::MinPeriod)) ? 20'(pads_pkg::MinPeriod)
                                                          : in_ch.period_us;
          state <= S_RAW;
          pend <= 1'b0;
        end
        S_RAW: if (!pend) begin
          if (pos <= negv || dd >= span) begin
            raw <= '0; state <= S_AL1;
          end else begin
            dnum <= 64'(dd) << 16; dden <= 64'(span); dstart <= 1'b1; pend <= 1'b1;
          end
        end else if (ddone) begin
          raw <= dq[15:0]; pend <= 1'b0; state <= S_AL1;
        end
        S_AL1: begin
          pfc <= 36'(p) * 36'(cut_a);
          state <= S_AL2;
        end
        S_AL2: if (!pend) begin
          kfc <= 64'(pfc) * 64'(pads_pkg::TwoPiQ16);
          pend <= 1'b1;
        end else if (!dstart && !ddone && ret != S_AL2) begin
          dnum <= pads_pkg::MicroQ16 << 16;
          dden <= pads_pkg::MicroQ16 + kfc;
          dstart <= 1'b1; ret <= S_AL2;
        end else if (ddone) begin
          alpha <= 17'(65536 - 64'(dq));
          pend <= 1'b0;
          if (first) begin
            first <= 1'b0; last_raw <= raw; unwr <= 32'(raw); acc_a <= 32'(raw);
            prev_out <= raw; state <= S_SP; ret <= S_IDLE;
          end else begin
            last_raw <= raw;
            unwr <= unwr + 32'(wdiff(raw, last_raw));
            e33 <= 33'(signed'(unwr + 32'(wdiff(raw, last_raw)) - acc_a));
            state <= S_MUL; ret <= S_AF;
            mcnt <= 5'd17;
            prod <= '0;
          end
        end
        S_MUL: begin
          if (mcnt == 5'd17) begin
            neg <= e33[32];
            mulb <= e33[32] ? 64'(-e33) : 64'(e33);
            mula <= alpha;
            mcnt <= mcnt - 5'd1;
          end else begin
            if (mula[0]) prod <= prod + mulb;
            mula <= mula >> 1;
            mulb <= mulb << 1;
            mcnt <= mcnt - 5'd1;
            if (mcnt == 5'd0) state <= ret;
          end
        end
        S_AF: begin
          acc_a <= acc_a + 32'(qv);
          raw <= 16'(acc_a + 32'(qv));
          state <= S_SP;
        end
        S_SP: if (!pend) begin
          prev_out <= raw;
          if (settle != 6'd0) begin
            settle <= settle - 6'd1;
            state <= S_OUT;
          end else begin
            neg <= wdiff(raw, prev_out) < 0;
            dnum <= 64'(wdiff(raw, prev_out) < 0 ? -wdiff(raw, prev_out)
                                                : wdiff(raw, prev_out)) * 64'd1000000;
            dden <= 64'(p);
            dstart <= 1'b1; pend <= 1'b1;
          end
        end else if (ddone) begin
          spd <= neg ? -34'(dq) : 34'(dq);
          pend <= 1'b0; state <= S_SA1;
        end
        S_SA1: begin
          pfc <= 36'(p) * 36'(cut_s);
          state <= S_SA2;
        end
        S_SA2: if (!pend) begin
          kfc <= 64'(pfc) * 64'(pads_pkg::TwoPiQ16);
          pend <= 1'b1;
        end else if (!dstart && !ddone && ret != S_SA2) begin
          dnum <= pads_pkg::MicroQ16 << 16;
          dden <= pads_pkg::MicroQ16 + kfc;
          dstart <= 1'b1; ret <= S_SA2;
        end else if (ddone) begin
          alpha <= 17'(65536 - 64'(dq));
          pend <= 1'b0;
          e33 <= 33'(spd - 34'(acc_s));
          state <= S_MUL; ret <= S_SF; mcnt <= 5'd17; prod <= '0;
        end
        S_SF: begin
          if (nv > 34'sd2147483647) acc_s <= 32'h7FFFFFFF;
          else if (nv < -34'sd2147483648) acc_s <= 32'h80000000;
          else acc_s <= 32'(nv);
          out_ch.speed_valid <= 1'b1;
          out_ch.angle <= raw;
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        S_OUT: begin
          out_ch.speed_valid <= 1'b0;
          out_ch.angle <= raw;
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign out_ch.speed = acc_s;
endmodule
